// ===== design/bacr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bacr_pkg
// Shared widths, reset values, event codes and control types of the block
// average change reporter.
// ----------------------------------------------------------------------------
package bacr_pkg;

  localparam int TEMP_W        = 15;
  localparam int PRESS_W       = 17;
  localparam int HUMID_W       = 14;
  localparam int SEC_W         = 6;
  localparam int MIN_W         = 6;
  localparam int HOUR_W        = 5;
  localparam int CNT_W         = 8;
  localparam int TEMP_SUM_W    = 23;
  localparam int PRESS_SUM_W   = 25;
  localparam int HUMID_SUM_W   = 22;
  localparam int DIV_W         = 25;
  localparam int KIND_W        = 3;
  localparam int NUM_KINDS     = 8;
  localparam int TEMP_DELTA_W  = 14;
  localparam int PRESS_DELTA_W = 17;
  localparam int HUMID_DELTA_W = 14;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 17;
  localparam int IN_DATA_W     = 64;
  localparam int OUT_DATA_W    = 48;

  // Register reset values.
  localparam logic [CNT_W-1:0]         AVG_COUNT_RST   = 8'd25;
  localparam logic [TEMP_DELTA_W-1:0]  TEMP_DELTA_RST  = 14'd50;
  localparam logic [PRESS_DELTA_W-1:0] PRESS_DELTA_RST = 17'd1000;
  localparam logic [HUMID_DELTA_W-1:0] HUMID_DELTA_RST = 14'd200;

  // Previous clock values after reset, never a valid time.
  localparam logic [SEC_W-1:0]  PREV_SEC_RST  = 6'd63;
  localparam logic [MIN_W-1:0]  PREV_MIN_RST  = 6'd63;
  localparam logic [HOUR_W-1:0] PREV_HOUR_RST = 5'd31;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_AVG_COUNT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_DELTA  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_DELTA = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HUMID_DELTA = 2'd3;

  // Event kinds; the emission order follows the code order.
  localparam logic [KIND_W-1:0] EV_HUMID  = 3'd0;
  localparam logic [KIND_W-1:0] EV_TEMP   = 3'd1;
  localparam logic [KIND_W-1:0] EV_PRESS  = 3'd2;
  localparam logic [KIND_W-1:0] EV_SECOND = 3'd3;
  localparam logic [KIND_W-1:0] EV_MINUTE = 3'd4;
  localparam logic [KIND_W-1:0] EV_FIVE   = 3'd5;
  localparam logic [KIND_W-1:0] EV_HALF   = 3'd6;
  localparam logic [KIND_W-1:0] EV_HOUR   = 3'd7;

  // Channels in the order they pass through the divider.
  typedef logic [1:0] chan_t;
  localparam chan_t CH_TEMP  = 2'd0;
  localparam chan_t CH_PRESS = 2'd1;
  localparam chan_t CH_HUMID = 2'd2;
  localparam chan_t CH_LAST  = CH_HUMID;

  typedef struct packed {
    logic  load;
    logic  div_start;
    logic  div_store;
    logic  eval;
    logic  emit;
    chan_t chan;
  } bacr_cmd_t;

  typedef struct packed {
    logic drop;
    logic close;
    logic div_done;
    logic mask_empty;
    logic mask_last;
    logic out_free;
  } bacr_status_t;

  function automatic logic is_mult5(input logic [MIN_W-1:0] m);
    logic r;
    case (m)
      6'd0, 6'd5, 6'd10, 6'd15, 6'd20, 6'd25, 6'd30,
      6'd35, 6'd40, 6'd45, 6'd50, 6'd55, 6'd60: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_mult30(input logic [MIN_W-1:0] m);
    logic r;
    case (m)
      6'd0, 6'd30, 6'd60: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== design/bacr_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bacr_div
// Unsigned restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module bacr_div #(
  parameter int DIVIDEND_W = bacr_pkg::DIV_W,
  parameter int DIVISOR_W  = bacr_pkg::CNT_W
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  busy,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int STEP_W = $clog2(DIVIDEND_W + 1);

  logic [DIVISOR_W-1:0] rem;
  logic [DIVISOR_W-1:0] dsr;
  logic [STEP_W-1:0]    steps;
  logic [DIVISOR_W:0]   trial;
  logic                 fits;

  assign trial = {rem, quotient[DIVIDEND_W-1]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(DIVIDEND_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // The quotient register shifts the dividend out at the top while the
  // quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (busy) begin
      quotient <= {quotient[DIVIDEND_W-2:0], fits};
      rem      <= fits ? DIVISOR_W'(trial - {1'b0, dsr}) : trial[DIVISOR_W-1:0];
    end
  end

endmodule

// ===== design/bacr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bacr_dp
// Datapath: configuration registers, channel sums, block averages, change
// tests, clock event detection and the output word register.
// ----------------------------------------------------------------------------
module bacr_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  bacr_pkg::bacr_cmd_t               cmd,
  output bacr_pkg::bacr_status_t            status,
  input  logic [bacr_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic                              s_tuser,
  input  logic                              cfg_valid,
  input  logic [bacr_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bacr_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [bacr_pkg::OUT_DATA_W-1:0]   m_tdata,
  output logic [bacr_pkg::KIND_W-1:0]       m_tuser,
  output logic                              m_tlast
);

  import bacr_pkg::*;

  // Configuration.
  logic [CNT_W-1:0]         avg_count;
  logic [TEMP_DELTA_W-1:0]  temp_delta;
  logic [PRESS_DELTA_W-1:0] press_delta;
  logic [HUMID_DELTA_W-1:0] humid_delta;

  // Accumulation and averages.
  logic [CNT_W-1:0]              sample_count;
  logic signed [TEMP_SUM_W-1:0]  temp_sum;
  logic [PRESS_SUM_W-1:0]        press_sum;
  logic [HUMID_SUM_W-1:0]        humid_sum;
  logic signed [TEMP_W-1:0]      temp_avg;
  logic [PRESS_W-1:0]            press_avg;
  logic [HUMID_W-1:0]            humid_avg;
  logic signed [TEMP_W-1:0]      temp_last_sent;
  logic [PRESS_W-1:0]            press_last_sent;
  logic [HUMID_W-1:0]            humid_last_sent;
  logic                          first_pass;
  logic                          disconnected;
  logic                          drop;
  logic                          close;
  logic [SEC_W-1:0]              prev_second;
  logic [MIN_W-1:0]              prev_minute;
  logic [HOUR_W-1:0]             prev_hour;
  logic [SEC_W-1:0]              cur_second;
  logic [MIN_W-1:0]              cur_minute;
  logic [HOUR_W-1:0]             cur_hour;
  logic [NUM_KINDS-1:0]          mask;

  // Input fields.
  logic signed [TEMP_W-1:0] in_temp;
  logic [PRESS_W-1:0]       in_press;
  logic [HUMID_W-1:0]       in_humid;
  logic [CNT_W-1:0]         count_inc;
  logic [CNT_W-1:0]         target;

  assign in_temp   = s_tdata[14:0];
  assign in_press  = s_tdata[31:15];
  assign in_humid  = s_tdata[45:32];
  assign count_inc = sample_count + 1'b1;
  assign target    = (avg_count == '0) ? CNT_W'(1) : avg_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_count   <= AVG_COUNT_RST;
      temp_delta  <= TEMP_DELTA_RST;
      press_delta <= PRESS_DELTA_RST;
      humid_delta <= HUMID_DELTA_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_AVG_COUNT:   avg_count   <= cfg_data[CNT_W-1:0];
        REG_TEMP_DELTA:  temp_delta  <= cfg_data[TEMP_DELTA_W-1:0];
        REG_PRESS_DELTA: press_delta <= cfg_data[PRESS_DELTA_W-1:0];
        REG_HUMID_DELTA: humid_delta <= cfg_data[HUMID_DELTA_W-1:0];
        default: ;
      endcase
    end
  end

  // Divider, shared by the three channels.
  logic                          temp_neg;
  logic signed [TEMP_SUM_W-1:0]  temp_mag;
  logic [DIV_W-1:0]              dividend;
  logic [DIV_W-1:0]              quotient;
  logic                          div_busy;
  logic                          div_done;
  logic [TEMP_W-1:0]             temp_q;

  assign temp_neg = temp_sum[TEMP_SUM_W-1];
  assign temp_mag = temp_neg ? -temp_sum : temp_sum;
  assign temp_q   = quotient[TEMP_W-1:0];

  always_comb begin
    case (cmd.chan)
      CH_TEMP:  dividend = DIV_W'(unsigned'(temp_mag));
      CH_PRESS: dividend = DIV_W'(press_sum);
      CH_HUMID: dividend = DIV_W'(humid_sum);
      default:  dividend = '0;
    endcase
  end

  bacr_div #(
    .DIVIDEND_W (DIV_W),
    .DIVISOR_W  (CNT_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (dividend),
    .divisor  (sample_count),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (quotient)
  );

  // Change tests against the last reported values.
  logic signed [TEMP_W:0]    temp_diff;
  logic signed [PRESS_W:0]   press_diff;
  logic signed [HUMID_W:0]   humid_diff;
  logic [TEMP_W:0]           temp_absd;
  logic [PRESS_W:0]          press_absd;
  logic [HUMID_W:0]          humid_absd;
  logic [NUM_KINDS-1:0]      mask_new;
  logic                      sec_new;
  logic                      min_new;

  assign temp_diff  = {temp_last_sent[TEMP_W-1], temp_last_sent} - {temp_avg[TEMP_W-1], temp_avg};
  assign press_diff = $signed({1'b0, press_last_sent}) - $signed({1'b0, press_avg});
  assign humid_diff = $signed({1'b0, humid_last_sent}) - $signed({1'b0, humid_avg});
  assign temp_absd  = temp_diff[TEMP_W]   ? unsigned'(-temp_diff)  : unsigned'(temp_diff);
  assign press_absd = press_diff[PRESS_W] ? unsigned'(-press_diff) : unsigned'(press_diff);
  assign humid_absd = humid_diff[HUMID_W] ? unsigned'(-humid_diff) : unsigned'(humid_diff);

  assign sec_new = cur_second != prev_second;
  assign min_new = sec_new && (cur_minute != prev_minute);

  always_comb begin
    mask_new            = '0;
    mask_new[EV_HUMID]  = first_pass || (humid_absd > (HUMID_W+1)'(humid_delta));
    mask_new[EV_TEMP]   = first_pass || (temp_absd > (TEMP_W+1)'(temp_delta));
    mask_new[EV_PRESS]  = first_pass || (press_absd > (PRESS_W+1)'(press_delta));
    mask_new[EV_SECOND] = sec_new;
    mask_new[EV_MINUTE] = min_new;
    mask_new[EV_FIVE]   = min_new && is_mult5(cur_minute);
    mask_new[EV_HALF]   = min_new && is_mult30(cur_minute);
    mask_new[EV_HOUR]   = min_new && (cur_hour != prev_hour);
  end

  // Lowest pending event goes out first.
  logic [KIND_W-1:0]    next_kind;
  logic [NUM_KINDS-1:0] mask_rest;

  always_comb begin
    next_kind = '0;
    for (int i = NUM_KINDS - 1; i >= 0; i--) begin
      if (mask[i]) next_kind = KIND_W'(i);
    end
  end

  assign mask_rest = mask & (mask - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count    <= '0;
      temp_sum        <= '0;
      press_sum       <= '0;
      humid_sum       <= '0;
      temp_avg        <= '0;
      press_avg       <= '0;
      humid_avg       <= '0;
      temp_last_sent  <= '0;
      press_last_sent <= '0;
      humid_last_sent <= '0;
      first_pass      <= 1'b1;
      disconnected    <= 1'b0;
      drop            <= 1'b0;
      close           <= 1'b0;
      prev_second     <= PREV_SEC_RST;
      prev_minute     <= PREV_MIN_RST;
      prev_hour       <= PREV_HOUR_RST;
      mask            <= '0;
    end else begin
      if (cmd.load) begin
        if (disconnected || !s_tuser) begin
          disconnected <= 1'b1;
          drop         <= 1'b1;
          close        <= 1'b0;
        end else begin
          drop         <= 1'b0;
          temp_sum     <= temp_sum + TEMP_SUM_W'(in_temp);
          press_sum    <= press_sum + PRESS_SUM_W'(in_press);
          humid_sum    <= humid_sum + HUMID_SUM_W'(in_humid);
          sample_count <= count_inc;
          close        <= count_inc >= target;
        end
      end
      if (cmd.div_store) begin
        case (cmd.chan)
          CH_TEMP:  temp_avg  <= temp_neg ? -signed'(temp_q) : signed'(temp_q);
          CH_PRESS: press_avg <= quotient[PRESS_W-1:0];
          CH_HUMID: humid_avg <= quotient[HUMID_W-1:0];
          default: ;
        endcase
        if (cmd.chan == CH_LAST) begin
          temp_sum     <= '0;
          press_sum    <= '0;
          humid_sum    <= '0;
          sample_count <= '0;
        end
      end
      if (cmd.eval) begin
        mask       <= mask_new;
        first_pass <= 1'b0;
        if (mask_new[EV_HUMID])  humid_last_sent <= humid_avg;
        if (mask_new[EV_TEMP])   temp_last_sent  <= temp_avg;
        if (mask_new[EV_PRESS])  press_last_sent <= press_avg;
        if (mask_new[EV_SECOND]) prev_second     <= cur_second;
        if (mask_new[EV_MINUTE]) prev_minute     <= cur_minute;
        if (mask_new[EV_HOUR])   prev_hour       <= cur_hour;
      end else if (cmd.emit) begin
        mask <= mask_rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur_second <= s_tdata[51:46];
      cur_minute <= s_tdata[57:52];
      cur_hour   <= s_tdata[62:58];
    end
  end

  // Output word register; the controller loads it only while it is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      m_tuser <= next_kind;
      m_tlast <= mask_rest == '0;
      m_tdata <= {2'b00, humid_avg, press_avg, temp_avg};
    end
  end

  assign status.drop       = drop;
  assign status.close      = close;
  assign status.div_done   = div_done;
  assign status.mask_empty = mask == '0;
  assign status.mask_last  = (mask != '0) && (mask_rest == '0);
  assign status.out_free   = !m_tvalid || m_tready;

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!m_tvalid || m_tready))
    else $error("word loaded over a word not yet taken");

  a_disc_sticky: assert property (@(posedge clk) disable iff (rst)
    disconnected |=> disconnected)
    else $error("disconnected state cleared without reset");

  a_div_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !div_busy)
    else $error("divider started while busy");

  a_block_clear: assert property (@(posedge clk) disable iff (rst)
    (cmd.div_store && cmd.chan == CH_LAST) |=> (sample_count == '0 && temp_sum == '0))
    else $error("block not cleared after its averages were stored");

endmodule

// ===== design/bacr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bacr_ctrl
// Controller: sequences accept, block division, change evaluation and the
// emission of one result word per free output slot.
// ----------------------------------------------------------------------------
module bacr_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  bacr_pkg::bacr_status_t status,
  output bacr_pkg::bacr_cmd_t    cmd
);

  import bacr_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DSTART,
    ST_DWAIT,
    ST_EVAL,
    ST_EMIT
  } state_t;

  state_t state;
  state_t state_next;
  chan_t  chan;
  chan_t  chan_next;

  always_comb begin
    state_next    = state;
    chan_next     = chan;
    cmd           = '0;
    cmd.chan      = chan;
    case (state)
      ST_IDLE: begin
        // Ready is cleared by reset, and a word is only loaded when it is
        // really accepted, with valid and ready both high.
        if (s_tvalid && s_tready) begin
          cmd.load   = 1'b1;
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status.drop) begin
          state_next = ST_IDLE;
        end else if (status.close) begin
          chan_next  = CH_TEMP;
          state_next = ST_DSTART;
        end else begin
          state_next = ST_EVAL;
        end
      end
      ST_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (status.div_done) begin
          cmd.div_store = 1'b1;
          if (chan == CH_LAST) begin
            state_next = ST_EVAL;
          end else begin
            chan_next  = chan + 1'b1;
            state_next = ST_DSTART;
          end
        end
      end
      ST_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.mask_empty) begin
          state_next = ST_IDLE;
        end else if (status.out_free) begin
          cmd.emit = 1'b1;
          if (status.mask_last) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      chan     <= CH_TEMP;
      s_tready <= 1'b0;
    end else begin
      state    <= state_next;
      chan     <= chan_next;
      s_tready <= state_next == ST_IDLE;
    end
  end

endmodule

// ===== design/block_average_change_reporter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_average_change_reporter
// Sensor block averager that reports channel changes and clock events.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            contents
//  s_*      in         s_tvalid/s_tready    one sensor sample and wall clock
//  m_*      out        m_tvalid/m_tready    one event word, tlast ends a run
//  cfg_*    in         cfg_valid/cfg_ready  register index and write data
//
// A word that closes no block passes through the accept, check and evaluate
// states of the controller before its results are emitted; a dropped word
// goes from check straight back to accept.
// A word that closes a block also passes through the divider: for each of the
// three channel averages in turn it takes a start, 25 steps and a store.
// Results leave through a single output register; emission stalls while it
// is full, and the next word is taken once the last result is loaded.
// Reset is synchronous; no clearing pass is needed.
// ----------------------------------------------------------------------------
module block_average_change_reporter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // temperature[14:0], pressure[31:15], humidity[45:32], clock_second[51:46],
  // clock_minute[57:52], clock_hour[62:58], zero[63]
  input  logic [bacr_pkg::IN_DATA_W-1:0]      s_tdata,
  // sample_valid[0]
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // temp_average[14:0], press_average[31:15], humid_average[45:32], zero[47:46]
  output logic [bacr_pkg::OUT_DATA_W-1:0]     m_tdata,
  // event_kind[2:0]
  output logic [bacr_pkg::KIND_W-1:0]         m_tuser,
  output logic                                m_tlast,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bacr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bacr_pkg::CFG_DATA_W-1:0]     cfg_data
);

  import bacr_pkg::*;

  bacr_cmd_t    cmd;
  bacr_status_t status;

  assign cfg_ready = 1'b1;

  bacr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  bacr_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the block average change reporter. Sensor
// words go in through the input stream and are mirrored by a behavioural
// predictor of the averaging, change and clock event logic. Every report
// word leaving the block is compared with the oldest predicted report. A
// directed part covers field extremes, delta boundaries, clock events and
// block closing. A random part follows under several register settings,
// with random idling on both streams, one long output stall and a final
// sensor failure.
// ----------------------------------------------------------------------------
module tb;
  import bacr_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  // Settling time after the last report, so that a block close can run out.
  localparam int SETTLE = 200;

  typedef struct {
    logic signed [TEMP_W-1:0] temp;
    logic [PRESS_W-1:0]       press;
    logic [HUMID_W-1:0]       humid;
    logic                     valid;
    logic [SEC_W-1:0]         second;
    logic [MIN_W-1:0]         minute;
    logic [HOUR_W-1:0]        hour;
  } sample_t;

  typedef struct {
    logic [KIND_W-1:0]        kind;
    logic signed [TEMP_W-1:0] temp;
    logic [PRESS_W-1:0]       press;
    logic [HUMID_W-1:0]       humid;
    logic                     last;
  } report_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  logic [IN_DATA_W-1:0]     s_tdata = '0;
  logic                     s_tuser = 1'b0;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]    m_tdata;
  logic [KIND_W-1:0]        m_tuser;
  logic                     m_tlast;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  block_average_change_reporter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Predictor registers and state.
  int avg_target = int'(AVG_COUNT_RST);
  int temp_thr   = int'(TEMP_DELTA_RST);
  int press_thr  = int'(PRESS_DELTA_RST);
  int humid_thr  = int'(HUMID_DELTA_RST);
  int acc_n, acc_t, acc_p, acc_h;
  int avg_t, avg_p, avg_h;
  int sent_t, sent_p, sent_h;
  bit awaiting_first = 1'b1;
  bit link_lost = 1'b0;
  int last_sec = int'(PREV_SEC_RST);
  int last_min = int'(PREV_MIN_RST);
  int last_hr  = int'(PREV_HOUR_RST);

  sample_t sample_q[$];
  report_t report_q[$];
  int      n_queued, n_accepted, n_errors;
  int      cycles;
  logic    idle_en = 1'b1;

  // Stimulus wall clock and signal levels.
  int wc_sec, wc_min, wc_hr;
  int base_t, base_p, base_h, spread;
  int avg_plan[8] = '{255, 1, 3, 25, 8, 2, 0, 5};

  function automatic int abs_diff(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void predict_reports(sample_t s);
    logic [KIND_W-1:0] kinds[$];
    int target;
    report_t r;
    if (link_lost) return;
    if (!s.valid) begin
      link_lost = 1'b1;
      return;
    end
    acc_t += int'(s.temp);
    acc_p += int'(s.press);
    acc_h += int'(s.humid);
    acc_n++;
    target = (avg_target == 0) ? 1 : avg_target;
    if (acc_n >= target) begin
      // Integer division truncates toward zero, as the block does.
      avg_t = acc_t / acc_n;
      avg_p = acc_p / acc_n;
      avg_h = acc_h / acc_n;
      acc_t = 0;
      acc_p = 0;
      acc_h = 0;
      acc_n = 0;
    end
    if (awaiting_first || abs_diff(sent_h, avg_h) > humid_thr) begin
      kinds.push_back(EV_HUMID);
      sent_h = avg_h;
    end
    if (awaiting_first || abs_diff(sent_t, avg_t) > temp_thr) begin
      kinds.push_back(EV_TEMP);
      sent_t = avg_t;
    end
    if (awaiting_first || abs_diff(sent_p, avg_p) > press_thr) begin
      kinds.push_back(EV_PRESS);
      sent_p = avg_p;
    end
    awaiting_first = 1'b0;
    if (int'(s.second) != last_sec) begin
      last_sec = int'(s.second);
      kinds.push_back(EV_SECOND);
      if (int'(s.minute) != last_min) begin
        last_min = int'(s.minute);
        kinds.push_back(EV_MINUTE);
        if (int'(s.minute) % 5 == 0) kinds.push_back(EV_FIVE);
        if (int'(s.minute) % 30 == 0) kinds.push_back(EV_HALF);
        if (int'(s.hour) != last_hr) begin
          last_hr = int'(s.hour);
          kinds.push_back(EV_HOUR);
        end
      end
    end
    foreach (kinds[i]) begin
      r.kind  = kinds[i];
      r.temp  = TEMP_W'(avg_t);
      r.press = PRESS_W'(avg_p);
      r.humid = HUMID_W'(avg_h);
      r.last  = (i == kinds.size() - 1);
      report_q.push_back(r);
    end
  endfunction

  function automatic void check_field(string field, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      n_errors++;
    end
  endfunction

  function automatic sample_t mk(int t, int p, int h, int sec, int mn, int hr);
    sample_t s;
    s.temp   = TEMP_W'(t);
    s.press  = PRESS_W'(p);
    s.humid  = HUMID_W'(h);
    s.valid  = 1'b1;
    s.second = SEC_W'(sec);
    s.minute = MIN_W'(mn);
    s.hour   = HOUR_W'(hr);
    return s;
  endfunction

  // A clock that ticks or holds and noisy readings around slowly moving levels,
  // with the odd jump to any clock value and the odd word of random bits.
  function automatic sample_t next_sample();
    sample_t s;
    int r;
    r = $urandom_range(0, 99);
    if (r >= 40 && r < 85) begin
      wc_sec++;
      if (wc_sec >= 60) begin
        wc_sec = 0;
        wc_min++;
        if (wc_min >= 60) begin
          wc_min = 0;
          wc_hr++;
          if (wc_hr >= 24) wc_hr = 0;
        end
      end
    end else if (r >= 85 && r < 93) begin
      wc_sec = 59;
      if ($urandom_range(0, 3) == 0) wc_min = 59;
    end else if (r >= 93) begin
      wc_sec = $urandom_range(0, 63);
      wc_min = $urandom_range(0, 63);
      wc_hr  = $urandom_range(0, 31);
    end
    if ($urandom_range(0, 29) == 0) begin
      base_t = int'($urandom_range(0, 12500)) - 4000;
      base_p = $urandom_range(30000, 100000);
      base_h = $urandom_range(500, 9500);
    end
    if ($urandom_range(0, 9) == 0) begin
      s.temp  = TEMP_W'($urandom);
      s.press = PRESS_W'($urandom);
      s.humid = HUMID_W'($urandom);
    end else begin
      s.temp  = TEMP_W'(base_t + int'($urandom_range(0, 2 * spread)) - spread);
      s.press = PRESS_W'(base_p + 10 * (int'($urandom_range(0, 2 * spread)) - spread));
      s.humid = HUMID_W'(base_h + int'($urandom_range(0, 2 * spread)) - spread);
    end
    s.valid  = 1'b1;
    s.second = SEC_W'(wc_sec);
    s.minute = MIN_W'(wc_min);
    s.hour   = HOUR_W'(wc_hr);
    return s;
  endfunction

  task automatic queue_sample(input sample_t s);
    sample_q.push_back(s);
    n_queued++;
  endtask

  // Waits until every queued word is taken and every report has arrived,
  // then lets a block close that caused no report run out.
  task automatic drain();
    while (n_accepted != n_queued || report_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(value);
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input int avg, input int dt, input int dp, input int dh);
    write_reg(REG_AVG_COUNT, avg);
    write_reg(REG_TEMP_DELTA, dt);
    write_reg(REG_PRESS_DELTA, dp);
    write_reg(REG_HUMID_DELTA, dh);
  endtask

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin : drive_samples
    sample_t nxt;
    int gap_left;
    if (rst) begin
      s_tvalid <= 1'b0;
      gap_left = 0;
    end else if (!s_tvalid || s_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        nxt = sample_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, nxt.hour, nxt.minute, nxt.second, nxt.humid, nxt.press,
                     nxt.temp};
        s_tuser  <= nxt.valid;
        if (idle_en && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 10);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : accept_reports
    int words_taken;
    int hold_left;
    int stall_left;
    bit long_hold_done;
    if (rst) begin
      m_tready <= 1'b0;
      words_taken = 0;
      hold_left = 0;
      stall_left = 0;
      long_hold_done = 1'b0;
    end else begin
      if (m_tvalid && m_tready) words_taken++;
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!long_hold_done && words_taken >= 40 && sample_q.size() > 10) begin
        // Long stall so the block fills up and pushes back on its input.
        long_hold_done = 1'b1;
        hold_left = 400;
        m_tready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (idle_en && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watch_ports
    sample_t got;
    report_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (report_q.size() == 0) begin
          $error("report word with no expectation, event_kind %0d", m_tuser);
          n_errors++;
        end else begin
          want = report_q.pop_front();
          check_field("event_kind", int'(want.kind), int'(m_tuser));
          check_field("temp_average", int'(want.temp), int'($signed(m_tdata[14:0])));
          check_field("press_average", int'(want.press), int'(m_tdata[31:15]));
          check_field("humid_average", int'(want.humid), int'(m_tdata[45:32]));
          check_field("last_of_run", int'(want.last), int'(m_tlast));
        end
      end
      if (s_tvalid && s_tready) begin
        got.temp   = s_tdata[14:0];
        got.press  = s_tdata[31:15];
        got.humid  = s_tdata[45:32];
        got.second = s_tdata[51:46];
        got.minute = s_tdata[57:52];
        got.hour   = s_tdata[62:58];
        got.valid  = s_tuser;
        predict_reports(got);
        n_accepted++;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_AVG_COUNT:   avg_target = int'(cfg_data[CNT_W-1:0]);
          REG_TEMP_DELTA:  temp_thr   = int'(cfg_data[TEMP_DELTA_W-1:0]);
          REG_PRESS_DELTA: press_thr  = int'(cfg_data[PRESS_DELTA_W-1:0]);
          REG_HUMID_DELTA: humid_thr  = int'(cfg_data[HUMID_DELTA_W-1:0]);
          default: ;
        endcase
      end
    end
  end

  initial begin
    int dt, dp, dh;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Every sample closes a block and any difference is reported. The first
    // word matches the reset clock, so only the three change reports appear.
    configure(1, 0, 0, 0);
    queue_sample(mk(-16384, 0, 0, 63, 63, 31));
    queue_sample(mk(16383, 131071, 16383, 0, 0, 0));
    queue_sample(mk(16383, 131071, 16383, 1, 0, 0));
    queue_sample(mk(16383, 131071, 16383, 1, 0, 0));
    queue_sample(mk(-4000, 110000, 10000, 2, 5, 0));
    queue_sample(mk(8500, 0, 5000, 3, 30, 1));
    queue_sample(mk(8500, 0, 5000, 4, 60, 1));
    queue_sample(mk(1234, 55555, 4321, 5, 61, 24));
    queue_sample(mk(1234, 55555, 4321, 5, 62, 24));
    queue_sample(mk(0, 0, 0, 63, 63, 31));
    drain();

    // A change of exactly the delta stays quiet.
    configure(1, 100, 1000, 200);
    queue_sample(mk(100, 1000, 200, 63, 63, 31));
    queue_sample(mk(101, 1001, 201, 63, 63, 31));
    queue_sample(mk(1, 1, 1, 63, 63, 31));
    queue_sample(mk(0, 0, 0, 63, 63, 31));
    drain();

    // Negative sums must truncate toward zero; leave three samples pending.
    configure(4, 0, 0, 0);
    queue_sample(mk(-1, 131071, 16383, 10, 63, 31));
    queue_sample(mk(-2, 131071, 16383, 11, 63, 31));
    queue_sample(mk(-2, 131071, 16383, 12, 63, 31));
    queue_sample(mk(0, 131071, 16383, 13, 63, 31));
    repeat (3) queue_sample(mk(-16384, 0, 0, 14, 63, 31));
    drain();

    // A zero count acts as one and closes the pending block over all four.
    configure(0, 16383, 131071, 16383);
    queue_sample(mk(-16384, 0, 0, 15, 63, 31));
    queue_sample(mk(777, 64000, 3000, 15, 63, 31));
    queue_sample(mk(-3999, 1, 9999, 16, 63, 31));
    drain();

    wc_sec = 0;
    wc_min = 0;
    wc_hr  = 0;
    base_t = 2000;
    base_p = 101300;
    base_h = 4500;
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(0, 3))
        0: begin
          dt = 0;
          dp = 0;
          dh = 0;
        end
        1: begin
          dt = 16383;
          dp = 131071;
          dh = 16383;
        end
        default: begin
          dt = $urandom_range(0, 300);
          dp = $urandom_range(0, 3000);
          dh = $urandom_range(0, 600);
        end
      endcase
      configure(avg_plan[ph], dt, dp, dh);
      idle_en <= (ph < 6) && (ph != 3);
      spread = $urandom_range(0, 400);
      repeat ((ph == 0) ? 260 : 35) queue_sample(next_sample());
      drain();
    end

    // The sensor fails: the block goes quiet for good.
    queue_sample(mk(0, 0, 0, 0, 0, 0));
    sample_q[sample_q.size() - 1].valid = 1'b0;
    repeat (5) queue_sample(next_sample());
    drain();

    if (n_errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
